>>> design/crbp_pkg.sv
package crbp_pkg;

   // Pool geometry.
   localparam int NIC_COUNT   = 4;
   localparam int LARGE_COUNT = 32;
   localparam int LARGE_SIZE  = 1536;
   localparam int SMALL_COUNT = 16;
   localparam int SMALL_SIZE  = 256;

   // Field widths.
   localparam int ADDR_W      = 24;
   localparam int LEN_W       = 16;
   localparam int NIC_W       = 2;
   localparam int CNT_W       = 16;
   localparam int LARGE_IDX_W = 5;
   localparam int SMALL_IDX_W = 4;
   localparam int IDX_W       = 5;
   localparam int CSR_IDX_W   = 3;

   // Request modes.
   localparam logic [1:0] MODE_ALLOC  = 2'd0;
   localparam logic [1:0] MODE_FREE   = 2'd1;
   localparam logic [1:0] MODE_LOOKUP = 2'd2;

   // Response status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_BUFFER = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   // First index of the small base registers; the large bases sit below it.
   localparam logic [CSR_IDX_W-1:0] CSR_SMALL_BASE0 = 3'd4;

   typedef struct packed {
      logic [1:0]        mode;
      logic [NIC_W-1:0]  nic;
      logic [LEN_W-1:0]  length;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [ADDR_W-1:0] phys_address;
      logic              is_large;
      logic [IDX_W-1:0]  buffer_index;
      logic [CNT_W-1:0]  alloc_total;
      logic [CNT_W-1:0]  fail_total;
      logic [CNT_W-1:0]  free_total;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic prepare;
      logic execute;
   } cmd_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_PREP,
      FSM_EXEC,
      FSM_RESP
   } fsm_state_type;

   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] idx;
   } match_type;

   // Finds the slot whose offset from the block base equals off. Slot offsets
   // are distinct, so at most one compare fires; the lowest index wins anyway.
   function automatic match_type find_slot(logic [ADDR_W-1:0] off, int count, int size);
      match_type m;
      m = '0;
      for (int i = LARGE_COUNT - 1; i >= 0; i--) begin
         if (i < count && off == ADDR_W'(i * size)) begin
            m.hit = 1'b1;
            m.idx = IDX_W'(i);
         end
      end
      return m;
   endfunction

endpackage

>>> design/two_class_rx_buffer_pool.sv
// Receive buffer pool for four interfaces, each with a small and a large class
// of fixed-size buffers laid out at a programmable base address. A request is
// taken when start is high and busy is low, and its response appears on
// rsp_item, marked by a one-cycle rsp_valid strobe; the receiver cannot stall,
// so it must capture the response in that cycle. Each request passes in turn
// through capture, forming the address offsets from both block bases and the
// ring-head addresses, comparing the offsets against every slot and updating
// the busy marks, heads and counters, and presenting the response. The
// sequencing is set by the controller state machine, which holds busy high
// from the cycle after acceptance until the response cycle ends. Base
// registers are written through the csr_ port and should only be changed while
// busy is low.
module two_class_rx_buffer_pool (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  crbp_pkg::req_type                 req_item,
   output logic                              rsp_valid,
   output crbp_pkg::rsp_type                 rsp_item,
   input  logic                              csr_we,
   input  logic [crbp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [crbp_pkg::ADDR_W-1:0]       csr_wdata
);
   import crbp_pkg::*;

   // Command bundle from the controller to the datapath.
   cmd_type cmd;

   // The controller sequences each request through capture, prepare,
   // execute and respond.
   crbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // The datapath holds the base registers, the per-interface pool state and
   // the response register.
   crbp_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_item  (rsp_item)
   );

`ifndef ASSERT_OFF
   // An accepted request is always followed by its response on rsp_valid.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("response did not follow an accepted request");

   // The response strobe lasts one cycle and the block is then free again.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("response strobe longer than one cycle");

   // A response never carries the unused status code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.status == STATUS_OK || rsp_item.status == STATUS_NO_BUFFER
                     || rsp_item.status == STATUS_NOT_FOUND))
      else $error("response with an undefined status");
`endif

endmodule

>>> design/crbp_ctrl.sv
module crbp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output logic                   rsp_valid,
   output crbp_pkg::cmd_type      cmd
);
   import crbp_pkg::*;

   fsm_state_type state_ff;
   fsm_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (start) begin
               state_in = FSM_PREP;
            end
         end
         FSM_PREP: state_in = FSM_EXEC;
         FSM_EXEC: state_in = FSM_RESP;
         FSM_RESP: state_in = FSM_IDLE;
         default:  state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         FSM_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         FSM_PREP: cmd.prepare = 1'b1;
         FSM_EXEC: cmd.execute = 1'b1;
         FSM_RESP: rsp_valid   = 1'b1;
         default:  busy        = 1'b1;
      endcase
   end

endmodule

>>> design/crbp_datapath.sv
module crbp_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  crbp_pkg::cmd_type                   cmd,
   input  crbp_pkg::req_type                   req_item,
   input  logic                                csr_we,
   input  logic [crbp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [crbp_pkg::ADDR_W-1:0]         csr_wdata,
   output crbp_pkg::rsp_type                   rsp_item
);
   import crbp_pkg::*;

   req_type req_ff;

   logic [ADDR_W-1:0] large_base_ff [NIC_COUNT];
   logic [ADDR_W-1:0] small_base_ff [NIC_COUNT];

   logic [LARGE_COUNT-1:0] large_busy_ff  [NIC_COUNT];
   logic [SMALL_COUNT-1:0] small_busy_ff  [NIC_COUNT];
   logic [LARGE_IDX_W-1:0] large_next_ff  [NIC_COUNT];
   logic [SMALL_IDX_W-1:0] small_next_ff  [NIC_COUNT];
   logic [CNT_W-1:0]       allocs_done_ff [NIC_COUNT];
   logic [CNT_W-1:0]       allocs_fail_ff [NIC_COUNT];
   logic [CNT_W-1:0]       frees_done_ff  [NIC_COUNT];

   logic [ADDR_W-1:0] off_large_ff, off_large_in;
   logic [ADDR_W-1:0] off_small_ff, off_small_in;
   logic [ADDR_W-1:0] slot_large_ff, slot_large_in;
   logic [ADDR_W-1:0] slot_small_ff, slot_small_in;

   logic [LARGE_COUNT-1:0] large_busy_in;
   logic [SMALL_COUNT-1:0] small_busy_in;
   logic [LARGE_IDX_W-1:0] large_next_in;
   logic [SMALL_IDX_W-1:0] small_next_in;
   logic [CNT_W-1:0]       allocs_done_in;
   logic [CNT_W-1:0]       allocs_fail_in;
   logic [CNT_W-1:0]       frees_done_in;

   rsp_type rsp_ff, rsp_in;

   logic             nic_ok;
   logic             csr_small;
   logic [NIC_W-1:0] csr_nic;
   match_type        large_hit;
   match_type        small_hit;

   assign nic_ok    = {1'b0, req_ff.nic} < (NIC_W + 1)'(NIC_COUNT);
   assign csr_small = csr_index >= CSR_SMALL_BASE0;
   assign csr_nic   = csr_index[NIC_W-1:0];

   // Base address registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < NIC_COUNT; n++) begin
            large_base_ff[n] <= '0;
            small_base_ff[n] <= '0;
         end
      end else if (csr_we && ({1'b0, csr_nic} < (NIC_W + 1)'(NIC_COUNT))) begin
         if (csr_small) begin
            small_base_ff[csr_nic] <= csr_wdata;
         end else begin
            large_base_ff[csr_nic] <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_item;
      end
   end

   // Prepare: offsets of the address from both block bases, and the
   // addresses of both ring heads.
   always_comb begin
      off_large_in  = req_ff.address - large_base_ff[req_ff.nic];
      off_small_in  = req_ff.address - small_base_ff[req_ff.nic];
      slot_large_in = large_base_ff[req_ff.nic]
                    + ADDR_W'(32'(large_next_ff[req_ff.nic]) * LARGE_SIZE);
      slot_small_in = small_base_ff[req_ff.nic]
                    + ADDR_W'(32'(small_next_ff[req_ff.nic]) * SMALL_SIZE);
   end

   always_ff @(posedge clock) begin
      if (cmd.prepare) begin
         off_large_ff  <= off_large_in;
         off_small_ff  <= off_small_in;
         slot_large_ff <= slot_large_in;
         slot_small_ff <= slot_small_in;
      end
   end

   assign large_hit = find_slot(off_large_ff, LARGE_COUNT, LARGE_SIZE);
   assign small_hit = find_slot(off_small_ff, SMALL_COUNT, SMALL_SIZE);

   // Execute: pool update and response for the addressed interface.
   always_comb begin
      large_busy_in  = large_busy_ff[req_ff.nic];
      small_busy_in  = small_busy_ff[req_ff.nic];
      large_next_in  = large_next_ff[req_ff.nic];
      small_next_in  = small_next_ff[req_ff.nic];
      allocs_done_in = allocs_done_ff[req_ff.nic];
      allocs_fail_in = allocs_fail_ff[req_ff.nic];
      frees_done_in  = frees_done_ff[req_ff.nic];
      rsp_in         = '0;
      rsp_in.status  = STATUS_NOT_FOUND;

      if (req_ff.mode == MODE_ALLOC) begin
         if (req_ff.length <= LEN_W'(SMALL_SIZE)) begin
            rsp_in.buffer_index = IDX_W'(small_next_ff[req_ff.nic]);
            if (!small_busy_ff[req_ff.nic][small_next_ff[req_ff.nic]]) begin
               small_busy_in[small_next_ff[req_ff.nic]] = 1'b1;
               if (small_next_ff[req_ff.nic] == SMALL_IDX_W'(SMALL_COUNT - 1)) begin
                  small_next_in = '0;
               end else begin
                  small_next_in = small_next_ff[req_ff.nic] + 1'b1;
               end
               rsp_in.phys_address = slot_small_ff;
               rsp_in.status       = STATUS_OK;
            end else begin
               rsp_in.status = STATUS_NO_BUFFER;
            end
         end else begin
            rsp_in.is_large     = 1'b1;
            rsp_in.buffer_index = IDX_W'(large_next_ff[req_ff.nic]);
            if (!large_busy_ff[req_ff.nic][large_next_ff[req_ff.nic]]) begin
               large_busy_in[large_next_ff[req_ff.nic]] = 1'b1;
               if (large_next_ff[req_ff.nic] == LARGE_IDX_W'(LARGE_COUNT - 1)) begin
                  large_next_in = '0;
               end else begin
                  large_next_in = large_next_ff[req_ff.nic] + 1'b1;
               end
               rsp_in.phys_address = slot_large_ff;
               rsp_in.status       = STATUS_OK;
            end else begin
               rsp_in.status = STATUS_NO_BUFFER;
            end
         end
         if (rsp_in.status == STATUS_OK) begin
            allocs_done_in = allocs_done_in + 1'b1;
         end else begin
            allocs_fail_in = allocs_fail_in + 1'b1;
         end
      end else if (req_ff.mode == MODE_FREE || req_ff.mode == MODE_LOOKUP) begin
         if (large_hit.hit || small_hit.hit) begin
            rsp_in.status       = STATUS_OK;
            rsp_in.phys_address = req_ff.address;
            rsp_in.is_large     = large_hit.hit;
            rsp_in.buffer_index = large_hit.hit ? large_hit.idx : small_hit.idx;
            if (req_ff.mode == MODE_FREE) begin
               if (large_hit.hit) begin
                  large_busy_in[large_hit.idx[LARGE_IDX_W-1:0]] = 1'b0;
               end else begin
                  small_busy_in[small_hit.idx[SMALL_IDX_W-1:0]] = 1'b0;
               end
               frees_done_in = frees_done_in + 1'b1;
            end
         end
      end

      rsp_in.alloc_total = allocs_done_in;
      rsp_in.fail_total  = allocs_fail_in;
      rsp_in.free_total  = frees_done_in;

      if (!nic_ok) begin
         rsp_in        = '0;
         rsp_in.status = STATUS_NOT_FOUND;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < NIC_COUNT; n++) begin
            large_busy_ff[n]  <= '0;
            small_busy_ff[n]  <= '0;
            large_next_ff[n]  <= '0;
            small_next_ff[n]  <= '0;
            allocs_done_ff[n] <= '0;
            allocs_fail_ff[n] <= '0;
            frees_done_ff[n]  <= '0;
         end
      end else if (cmd.execute && nic_ok) begin
         large_busy_ff[req_ff.nic]  <= large_busy_in;
         small_busy_ff[req_ff.nic]  <= small_busy_in;
         large_next_ff[req_ff.nic]  <= large_next_in;
         small_next_ff[req_ff.nic]  <= small_next_in;
         allocs_done_ff[req_ff.nic] <= allocs_done_in;
         allocs_fail_ff[req_ff.nic] <= allocs_fail_in;
         frees_done_ff[req_ff.nic]  <= frees_done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_item = rsp_ff;

endmodule
